>>> src/clipped_pixel_alpha_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped pixel alpha blend unit
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_PIXEL_ALPHA_BLEND_UNIT_DEFINES_SVH
`define CLIPPED_PIXEL_ALPHA_BLEND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLPAB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLPAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/clpab_pkg.sv
// ----------------------------------------------------------------------------
// clpab_pkg
// Types, constants and the divide-by-255 helper for the alpha blend pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clpab_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] OPAQUE_MAX = 32'h00FF_FFFF;
  localparam logic [7:0]  FULL_ALPHA = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        vis;
    logic [12:0] x;
    logic [23:0] idx_mul;
    logic [15:0] aprod;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
  } s1_t;

  typedef struct packed {
    logic        vis;
    logic [23:0] idx;
    logic [7:0]  ea;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
  } s2_t;

  // Exact floor(v / 255) for v up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

>>> src/clpab_front.sv
// ----------------------------------------------------------------------------
// clpab_front
// First stage: colour decode, clipping, alpha product and row multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clpab_front import clpab_pkg::*; #(
  parameter int unsigned MAX_FRAME_DIM = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    valid_in,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic [31:0]             fg_color,
  input  wire logic [7:0]              coverage,
  input  wire logic [31:0]             background_pixel,
  input  wire logic [CFG_W-1:0]        frame_width,
  input  wire logic [CFG_W-1:0]        frame_height,
  output logic                         valid_out,
  output s1_t                          data_out
);

  logic             valid_r;
  s1_t              data_r;
  s1_t              data_nxt;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             opaque;
  logic [7:0]       calpha;
  logic [25:0]      row_prod;

  always_comb begin
    w_eff = ({19'b0, frame_width} > 32'(MAX_FRAME_DIM)) ? CFG_W'(MAX_FRAME_DIM) : frame_width;
    h_eff = ({19'b0, frame_height} > 32'(MAX_FRAME_DIM)) ? CFG_W'(MAX_FRAME_DIM)
                                                         : frame_height;
    opaque = (fg_color <= OPAQUE_MAX);
    calpha = opaque ? FULL_ALPHA : fg_color[7:0];
    row_prod = {13'b0, pos_y[12:0]} * {13'b0, w_eff};

    data_nxt.vis     = (coverage != 8'd0) && (calpha != 8'd0) && !pos_x[13] && !pos_y[13]
                       && (pos_x[12:0] < w_eff) && (pos_y[12:0] < h_eff);
    data_nxt.x       = pos_x[12:0];
    data_nxt.idx_mul = row_prod[23:0];
    data_nxt.aprod   = {8'b0, coverage} * {8'b0, calpha};
    data_nxt.fg_rgb  = opaque ? fg_color[23:0] : fg_color[31:8];
    data_nxt.bg_rgb  = background_pixel[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

`default_nettype wire

>>> src/clpab_alpha.sv
// ----------------------------------------------------------------------------
// clpab_alpha
// Second stage: effective alpha by divide-by-255 and final pixel index add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clpab_alpha import clpab_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire s1_t  data_in,
  output logic      valid_out,
  output s2_t       data_out
);

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  always_comb begin
    data_nxt.vis    = data_in.vis;
    data_nxt.idx    = data_in.idx_mul + {11'b0, data_in.x};
    data_nxt.ea     = div255(data_in.aprod);
    data_nxt.fg_rgb = data_in.fg_rgb;
    data_nxt.bg_rgb = data_in.bg_rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

`default_nettype wire

>>> src/clpab_mix.sv
// ----------------------------------------------------------------------------
// clpab_mix
// Third and fourth stages: per-channel weighted sums, then divide and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clpab_mix import clpab_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en_sum,
  input  wire logic    en_out,
  input  wire logic    valid_in,
  input  wire s2_t     data_in,
  output logic         sum_valid,
  output logic         valid_out,
  output logic         write_enable,
  output logic [23:0]  pixel_index,
  output logic [31:0]  new_pixel
);

  logic        sum_valid_r;
  logic        vis_r;
  logic [23:0] idx_r;
  logic [15:0] sum_r [3];
  logic [15:0] sum_nxt [3];
  logic [7:0]  ea_inv;

  logic        out_valid_r;
  logic        we_r;
  logic [23:0] idx_out_r;
  logic [31:0] pix_r;
  logic [31:0] pix_nxt;

  always_comb begin
    ea_inv = FULL_ALPHA - data_in.ea;
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = ({8'b0, data_in.fg_rgb[8*c +: 8]} * {8'b0, data_in.ea})
                 + ({8'b0, data_in.bg_rgb[8*c +: 8]} * {8'b0, ea_inv});
    end
  end

  always_comb begin
    pix_nxt = {FULL_ALPHA, div255(sum_r[2]), div255(sum_r[1]), div255(sum_r[0])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_sum) begin
        sum_valid_r <= valid_in;
      end
      if (en_out) begin
        out_valid_r <= sum_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      vis_r <= data_in.vis;
      idx_r <= data_in.idx;
      sum_r <= sum_nxt;
    end
    if (en_out) begin
      we_r      <= vis_r;
      idx_out_r <= vis_r ? idx_r : 24'd0;
      pix_r     <= vis_r ? pix_nxt : 32'd0;
    end
  end

  assign sum_valid    = sum_valid_r;
  assign valid_out    = out_valid_r;
  assign write_enable = we_r;
  assign pixel_index  = idx_out_r;
  assign new_pixel    = pix_r;

endmodule

`default_nettype wire

>>> src/clipped_pixel_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// Clipped pixel alpha blend unit
// Clips a pixel against the frame and blends it source-over onto the
// background, producing a write strobe, linear index and new pixel word.
//
// Usage: pixel beats enter on the in_ channel and leave on the out_ channel,
// both with valid and stall; a beat moves when valid is high and stall low.
// Every input beat gives exactly one output beat, in order. A rejected pixel
// leaves with write_enable low and zero index and pixel.
// The pipeline has four register stages: decode and multiply, alpha divide
// and index add, channel sums, channel divide into the output register.
// One beat is taken every cycle while the output is drained. Each stage
// advances when empty or when the stage after it advances, so bubbles are
// squeezed out under stall and nothing is lost. Frame width and height are
// written on the cfg_ channel (index 0 and 1); the user must do so only while
// the pipeline is empty, which the block does not enforce; cfg_ready is always
// high. Reset (rst_n low, synchronous) empties all stages and sets the frame
// to 1024 by 768. While out_stall holds, the output beat is kept unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "clipped_pixel_alpha_blend_unit_defines.svh"

module clipped_pixel_alpha_blend_unit import clpab_pkg::*; #(
  parameter int unsigned MAX_FRAME_DIM = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [POS_W-1:0]     in_pos_x,
  input  wire logic signed [POS_W-1:0]     in_pos_y,
  input  wire logic [31:0]                 in_fg_color,
  input  wire logic [7:0]                  in_coverage,
  input  wire logic [31:0]                 in_background_pixel,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_write_enable,
  output logic [IDX_W-1:0]                 out_pixel_index,
  output logic [31:0]                      out_new_pixel,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data
);

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;

  logic v1;
  logic v2;
  logic v3;
  logic en1;
  logic en2;
  logic en3;
  logic en4;
  s1_t  s1;
  s2_t  s2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(1024);
      frame_height_r <= CFG_W'(768);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default:          frame_width_r  <= frame_width_r;
      endcase
    end
  end

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  clpab_front #(
    .MAX_FRAME_DIM(MAX_FRAME_DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en1),
    .valid_in         (in_valid),
    .pos_x            (in_pos_x),
    .pos_y            (in_pos_y),
    .fg_color         (in_fg_color),
    .coverage         (in_coverage),
    .background_pixel (in_background_pixel),
    .frame_width      (frame_width_r),
    .frame_height     (frame_height_r),
    .valid_out        (v1),
    .data_out         (s1)
  );

  clpab_alpha u_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en2),
    .valid_in  (v1),
    .data_in   (s1),
    .valid_out (v2),
    .data_out  (s2)
  );

  clpab_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .en_sum       (en3),
    .en_out       (en4),
    .valid_in     (v2),
    .data_in      (s2),
    .sum_valid    (v3),
    .valid_out    (out_valid),
    .write_enable (out_write_enable),
    .pixel_index  (out_pixel_index),
    .new_pixel    (out_new_pixel)
  );

  `CLPAB_ASSERT_SAME(a_reject_zero, out_valid && !out_write_enable, (out_pixel_index == 24'd0) && (out_new_pixel == 32'd0), "rejected beat carries nonzero payload")
  `CLPAB_ASSERT_SAME(a_alpha_forced, out_valid && out_write_enable, out_new_pixel[31:24] == FULL_ALPHA, "written pixel alpha is not forced")
  `CLPAB_ASSERT_SAME(a_empty_out_accepts, !out_valid, !in_stall, "input stalled with empty output stage")
  `CLPAB_ASSERT_NEXT(a_stall_holds_pipe, out_valid && out_stall && v3 && v2 && v1, in_stall || !out_stall, "full pipeline took a beat under stall")

endmodule

`default_nettype wire

>>> sim/clipped_pixel_alpha_blend_unit_test.sv
// ----------------------------------------------------------------------------
// Clipped pixel alpha blend unit test
// Drives pixel beats through the blend unit under random idle and stall on both
// channels, and reprograms the frame size between phases, including zero and
// oversized frames. A scoreboard predicts each result from the clipping and
// source-over rules and compares every output beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_pixel_alpha_blend_unit_test;
  import clpab_pkg::*;

  localparam int MAX_FRAME_DIM = 4096;
  localparam int PIPE_FLUSH    = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_BEATS   = 270;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [31:0]             fg_color;
    logic [7:0]              coverage;
    logic [31:0]             background_pixel;
  } pixel_beat_t;

  typedef struct packed {
    logic             write_enable;
    logic [IDX_W-1:0] pixel_index;
    logic [31:0]      new_pixel;
  } blend_result_t;

  class blend_scoreboard;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    blend_result_t    expected_pixels[$];
    int               mismatches;

    function new();
      frame_width  = 13'd1024;
      frame_height = 13'd768;
      mismatches   = 0;
    endfunction

    function int clip_dim(logic [CFG_W-1:0] d);
      return (d > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(d);
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      case (r)
        REG_FRAME_WIDTH:  frame_width = v;
        REG_FRAME_HEIGHT: frame_height = v;
        default: ;
      endcase
    endfunction

    function blend_result_t blend_pixel(pixel_beat_t p);
      blend_result_t res;
      int            x;
      int            y;
      int            w;
      int            h;
      int            alpha;
      int            ea;
      int            fg_c;
      int            bg_c;
      logic [23:0]   rgb;
      logic          opaque;
      res    = '0;
      x      = $signed(p.pos_x);
      y      = $signed(p.pos_y);
      w      = clip_dim(frame_width);
      h      = clip_dim(frame_height);
      opaque = (p.fg_color <= OPAQUE_MAX);
      alpha  = opaque ? int'(FULL_ALPHA) : int'(p.fg_color[7:0]);
      rgb    = opaque ? p.fg_color[23:0] : p.fg_color[31:8];
      if (p.coverage == 0 || alpha == 0 || x < 0 || y < 0 || x >= w || y >= h) begin
        return res;
      end
      ea = int'(p.coverage) * alpha / 255;
      for (int c = 0; c < 3; c++) begin
        fg_c = int'(rgb[8*c +: 8]);
        bg_c = int'(p.background_pixel[8*c +: 8]);
        res.new_pixel[8*c +: 8] = 8'((fg_c * ea + bg_c * (255 - ea)) / 255);
      end
      res.new_pixel[31:24] = FULL_ALPHA;
      res.write_enable     = 1'b1;
      res.pixel_index      = IDX_W'(y * w + x);
      return res;
    endfunction

    function void note_pixel(pixel_beat_t p);
      expected_pixels.push_back(blend_pixel(p));
    endfunction

    function void check_pixel(blend_result_t got);
      blend_result_t want;
      if (expected_pixels.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("Result beat with nothing pending: we=%0b idx=%0d px=%h",
                   got.write_enable, got.pixel_index, got.new_pixel);
        end
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.write_enable !== want.write_enable || got.pixel_index !== want.pixel_index ||
          got.new_pixel !== want.new_pixel) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("Result beat differs: expected we=%0b idx=%0d px=%h, got we=%0b idx=%0d px=%h",
                   want.write_enable, want.pixel_index, want.new_pixel,
                   got.write_enable, got.pixel_index, got.new_pixel);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic [31:0]             in_fg_color;
  logic [7:0]              in_coverage;
  logic [31:0]             in_background_pixel;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_write_enable;
  logic [IDX_W-1:0]        out_pixel_index;
  logic [31:0]             out_new_pixel;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  blend_scoreboard sb;
  int              send_idle;
  int              recv_idle;
  int              cycles;

  clipped_pixel_alpha_blend_unit #(
    .MAX_FRAME_DIM(MAX_FRAME_DIM)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_fg_color        (in_fg_color),
    .in_coverage        (in_coverage),
    .in_background_pixel(in_background_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_enable   (out_write_enable),
    .out_pixel_index    (out_pixel_index),
    .out_new_pixel      (out_new_pixel),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    pixel_beat_t   seen;
    blend_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen = '{pos_x: in_pos_x, pos_y: in_pos_y, fg_color: in_fg_color,
                 coverage: in_coverage, background_pixel: in_background_pixel};
        sb.note_pixel(seen);
      end
      if (out_valid && !out_stall) begin
        got = '{write_enable: out_write_enable, pixel_index: out_pixel_index,
                new_pixel: out_new_pixel};
        sb.check_pixel(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pixel(pixel_beat_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_pos_x            <= p.pos_x;
    in_pos_y            <= p.pos_y;
    in_fg_color         <= p.fg_color;
    in_coverage         <= p.coverage;
    in_background_pixel <= p.background_pixel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pix(int x, int y, logic [31:0] fg, logic [7:0] cov, logic [31:0] bg);
    pixel_beat_t p;
    p.pos_x            = x[POS_W-1:0];
    p.pos_y            = y[POS_W-1:0];
    p.fg_color         = fg;
    p.coverage         = cov;
    p.background_pixel = bg;
    send_pixel(p);
  endtask

  function automatic pixel_beat_t random_pixel();
    pixel_beat_t p;
    int          w;
    int          h;
    int          x;
    int          y;
    int          pick;
    w = sb.clip_dim(sb.frame_width);
    h = sb.clip_dim(sb.frame_height);
    if ($urandom_range(99) < 80) begin
      x = int'($urandom_range(w + 3)) - 2;
      y = int'($urandom_range(h + 3)) - 2;
    end else begin
      x = int'($urandom_range(16383));
      y = int'($urandom_range(16383));
    end
    p.pos_x = x[POS_W-1:0];
    p.pos_y = y[POS_W-1:0];
    pick = $urandom_range(99);
    if (pick < 30) begin
      p.fg_color = {8'h00, 24'($urandom)};
    end else if (pick < 38) begin
      p.fg_color = {24'($urandom), 8'h00};
    end else begin
      p.fg_color = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 12) begin
      p.coverage = 8'h00;
    end else if (pick < 27) begin
      p.coverage = 8'hFF;
    end else begin
      p.coverage = 8'($urandom_range(255));
    end
    p.background_pixel = $urandom;
    return p;
  endfunction

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (PIPE_FLUSH) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(r, v);
    @(negedge clk);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain_pipeline();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      if (i == PHASE_BEATS / 2) drain_pipeline();
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    sb                  = new();
    cycles              = 0;
    send_idle           = 13;
    recv_idle           = 61;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_pos_x            = '0;
    in_pos_y            = '0;
    in_fg_color         = '0;
    in_coverage         = '0;
    in_background_pixel = '0;
    out_stall           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = REG_FRAME_WIDTH;
    cfg_data            = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pix(0, 0, 32'h00FF_FFFF, 8'hFF, 32'h0000_0000);
    pix(1023, 767, 32'h0012_3456, 8'hFF, 32'h89AB_CDEF);
    pix(1024, 5, 32'h0012_3456, 8'hFF, 32'h89AB_CDEF);
    pix(5, 768, 32'h0012_3456, 8'hFF, 32'h89AB_CDEF);
    pix(-1, 3, 32'h0012_3456, 8'hFF, 32'h89AB_CDEF);
    pix(3, -1, 32'h0012_3456, 8'hFF, 32'h89AB_CDEF);
    pix(-8192, 8191, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    pix(8191, -8192, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    pix(10, 10, 32'h00AB_CDEF, 8'h00, 32'h1234_5678);
    pix(11, 10, 32'hABCD_EF00, 8'hFF, 32'h1234_5678);
    pix(12, 10, 32'h0100_0000, 8'hFF, 32'h1234_5678);
    pix(13, 10, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
    pix(14, 10, 32'h8040_2001, 8'h01, 32'hA5A5_5A5A);
    pix(15, 10, 32'h2040_80C0, 8'hC8, 32'hFFFF_FFFF);
    pix(16, 10, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF);
    pix(100, 200, 32'hFFFF_FF80, 8'h80, 32'h00FF_00FF);

    set_frame(13'd4096, 13'd4096);
    pix(4095, 4095, 32'h1122_33FF, 8'hFF, 32'h0000_0000);
    pix(4096, 0, 32'h1122_33FF, 8'hFF, 32'h0000_0000);

    set_frame(13'd8191, 13'd8191);
    pix(4095, 4095, 32'h7F7F_7F7F, 8'h7F, 32'hFFFF_FFFF);
    pix(4096, 4096, 32'h7F7F_7F7F, 8'h7F, 32'hFFFF_FFFF);
    pix(0, 5000, 32'h7F7F_7F7F, 8'h7F, 32'hFFFF_FFFF);

    set_frame(13'd0, 13'd0);
    pix(0, 0, 32'h00FF_FFFF, 8'hFF, 32'h0000_0000);

    set_frame(13'd1, 13'd1);
    pix(0, 0, 32'hC0FF_EE99, 8'hE0, 32'h0102_0304);
    pix(1, 0, 32'hC0FF_EE99, 8'hE0, 32'h0102_0304);
    pix(0, 1, 32'hC0FF_EE99, 8'hE0, 32'h0102_0304);

    set_frame(CFG_W'($urandom_range(300, 1)), CFG_W'($urandom_range(300, 1)));
    run_phase(13, 61);
    set_frame(CFG_W'($urandom_range(8191, 1)), CFG_W'($urandom_range(8191, 1)));
    run_phase(61, 13);
    set_frame(CFG_W'($urandom_range(4096, 1024)), CFG_W'($urandom_range(4096, 1)));
    run_phase(0, 0);

    drain_pipeline();
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/clpab_pkg.sv
src/clpab_front.sv
src/clpab_alpha.sv
src/clpab_mix.sv
src/clipped_pixel_alpha_blend_unit.sv
sim/clipped_pixel_alpha_blend_unit_test.sv
